/* sv/sha1_byte_stream_hasher_assert.svh */
`ifndef SHA1_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHA1BSH_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SHA1BSH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sha1bsh_pkg.sv */
`default_nettype none

package sha1bsh_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned BLOCK_W   = 512;
   localparam int unsigned COUNT_W   = 61;
   localparam int unsigned POS_W     = 6;
   localparam int unsigned RND_W     = 7;
   localparam int unsigned WIDX_W    = 3;
   localparam int unsigned NUM_WORDS = 5;

   localparam logic [RND_W-1:0]  LAST_ROUND  = 7'd79;
   localparam logic [RND_W-1:0]  SCHED_LOAD  = 7'd16;
   localparam logic [POS_W-1:0]  LEN_POS     = 6'd56;
   localparam logic [POS_W-1:0]  LAST_POS    = 6'd63;
   localparam logic [POS_W-1:0]  LEN_BYTES   = 6'd8;
   localparam logic [WIDX_W-1:0] LAST_WORD   = 3'd4;
   localparam logic [7:0]        PAD_MARK    = 8'h80;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        word_last;
   } rsp_type;

   typedef enum logic [2:0] {
      SHIFT_NONE,
      SHIFT_DATA,
      SHIFT_MARK,
      SHIFT_ZERO,
      SHIFT_LEN
   } shift_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLOCK,
      ST_FOLD,
      ST_MARK,
      ST_ZERO,
      ST_PADBLK,
      ST_PADFOLD,
      ST_LASTBLK,
      ST_LASTFOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      shift_sel_type      shift_sel;
      logic               round_en;
      logic [RND_W-1:0]   rnd;
      logic               fold;
      logic               emit;
      logic [WIDX_W-1:0]  word_idx;
      logic               init;
   } cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             out_free;
   } sts_type;

   function automatic word_type init_word(input logic [WIDX_W-1:0] idx);
      word_type w;
      case (idx)
         3'd0:    w = 32'h67452301;
         3'd1:    w = 32'hEFCDAB89;
         3'd2:    w = 32'h98BADCFE;
         3'd3:    w = 32'h10325476;
         3'd4:    w = 32'hC3D2E1F0;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic word_type round_const(input logic [RND_W-1:0] rnd);
      word_type k;
      priority if (rnd < 7'd20) k = 32'h5A827999;
      else if (rnd < 7'd40)     k = 32'h6ED9EBA1;
      else if (rnd < 7'd60)     k = 32'h8F1BBCDC;
      else                      k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic word_type round_f(input logic [RND_W-1:0] rnd,
                                        input word_type b, input word_type c,
                                        input word_type d);
      word_type f;
      priority if (rnd < 7'd20) f = (b & c) | (~b & d);
      else if (rnd < 7'd40)     f = b ^ c ^ d;
      else if (rnd < 7'd60)     f = (b & c) | (b & d) | (c & d);
      else                      f = b ^ c ^ d;
      return f;
   endfunction

endpackage

`default_nettype wire

/* sv/sha1_byte_stream_hasher.sv */
// SHA-1 over a byte stream.
// req channel: one item per transfer, op absorb carries one message byte,
// op finish closes the message and requests its digest.
// rsp channel: five transfers per finish, the 32-bit digest words in
// big-endian order, word_last set on the fifth.
// An absorb transfer is taken in idle; the byte that completes a 64-byte block
// also starts the compression, 80 rounds at one round per cycle and then a fold
// into the chaining words, and no request is taken until that is done. A finish
// shifts in the padding bytes up to the length field, compresses one or two
// padding blocks, then emits the digest words.
// Results sit in an output register; a stalled receiver holds the digest
// words in place and stalls the emission, and with it the request channel;
// absorb transfers of the next message are taken as soon as the controller is back in idle.
// Reset loads the initial chaining words and clears the byte count; no result
// is pending after reset.
`default_nettype none

module sha1_byte_stream_hasher (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sha1bsh_pkg::req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sha1bsh_pkg::rsp_type      rsp_payload
);

   sha1bsh_pkg::cmd_type cmd;
   sha1bsh_pkg::sts_type sts;

   sha1bsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_payload.op),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha1bsh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_payload.data_byte),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* sv/sha1bsh_ctrl.sv */
`default_nettype none

module sha1bsh_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_op,
   input  wire sha1bsh_pkg::sts_type sts,
   output sha1bsh_pkg::cmd_type      cmd
);

   sha1bsh_pkg::state_type state_ff, state_in;
   logic [sha1bsh_pkg::RND_W-1:0]  rnd_ff, rnd_in;
   logic [sha1bsh_pkg::WIDX_W-1:0] widx_ff, widx_in;

   logic rnd_last;
   assign rnd_last = (rnd_ff == sha1bsh_pkg::LAST_ROUND);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha1bsh_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op == sha1bsh_pkg::OP_FINISH) begin
                  state_in = sha1bsh_pkg::ST_MARK;
               end else if (sts.pos == sha1bsh_pkg::LAST_POS) begin
                  state_in = sha1bsh_pkg::ST_BLOCK;
               end
            end
         end
         sha1bsh_pkg::ST_BLOCK: begin
            if (rnd_last) state_in = sha1bsh_pkg::ST_FOLD;
         end
         sha1bsh_pkg::ST_FOLD: state_in = sha1bsh_pkg::ST_IDLE;
         sha1bsh_pkg::ST_MARK: begin
            if (sts.pos == sha1bsh_pkg::LAST_POS) state_in = sha1bsh_pkg::ST_PADBLK;
            else                                  state_in = sha1bsh_pkg::ST_ZERO;
         end
         sha1bsh_pkg::ST_ZERO: begin
            if (sts.pos == sha1bsh_pkg::LEN_POS)       state_in = sha1bsh_pkg::ST_LASTBLK;
            else if (sts.pos == sha1bsh_pkg::LAST_POS) state_in = sha1bsh_pkg::ST_PADBLK;
         end
         sha1bsh_pkg::ST_PADBLK: begin
            if (rnd_last) state_in = sha1bsh_pkg::ST_PADFOLD;
         end
         sha1bsh_pkg::ST_PADFOLD: state_in = sha1bsh_pkg::ST_ZERO;
         sha1bsh_pkg::ST_LASTBLK: begin
            if (rnd_last) state_in = sha1bsh_pkg::ST_LASTFOLD;
         end
         sha1bsh_pkg::ST_LASTFOLD: state_in = sha1bsh_pkg::ST_EMIT;
         sha1bsh_pkg::ST_EMIT: begin
            if (sts.out_free && widx_ff == sha1bsh_pkg::LAST_WORD) begin
               state_in = sha1bsh_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1bsh_pkg::ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.shift_sel = sha1bsh_pkg::SHIFT_NONE;
      cmd.rnd       = rnd_ff;
      cmd.word_idx  = widx_ff;
      rnd_in        = rnd_ff;
      widx_in       = widx_ff;
      unique case (state_ff)
         sha1bsh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_op == sha1bsh_pkg::OP_ABSORB) begin
               cmd.shift_sel = sha1bsh_pkg::SHIFT_DATA;
            end
         end
         sha1bsh_pkg::ST_BLOCK, sha1bsh_pkg::ST_PADBLK, sha1bsh_pkg::ST_LASTBLK: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_last ? '0 : rnd_ff + 1'b1;
         end
         sha1bsh_pkg::ST_FOLD, sha1bsh_pkg::ST_PADFOLD, sha1bsh_pkg::ST_LASTFOLD: begin
            cmd.fold = 1'b1;
         end
         sha1bsh_pkg::ST_MARK: cmd.shift_sel = sha1bsh_pkg::SHIFT_MARK;
         sha1bsh_pkg::ST_ZERO: begin
            if (sts.pos == sha1bsh_pkg::LEN_POS) cmd.shift_sel = sha1bsh_pkg::SHIFT_LEN;
            else                                 cmd.shift_sel = sha1bsh_pkg::SHIFT_ZERO;
         end
         sha1bsh_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (widx_ff == sha1bsh_pkg::LAST_WORD) begin
                  cmd.init = 1'b1;
                  widx_in  = '0;
               end else begin
                  widx_in = widx_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1bsh_pkg::ST_IDLE;
         rnd_ff   <= '0;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         widx_ff  <= widx_in;
      end
   end

`include "sha1_byte_stream_hasher_assert.svh"

   `SHA1BSH_ASSERT_NOW(a_emit_needs_room, cmd.emit, sts.out_free, "digest word loaded over a pending word")
   `SHA1BSH_ASSERT_NOW(a_init_on_last, cmd.init, cmd.emit && widx_ff == sha1bsh_pkg::LAST_WORD, "chain reinit before last digest word")
   `SHA1BSH_ASSERT_NOW(a_idle_round_zero, state_ff == sha1bsh_pkg::ST_IDLE, rnd_ff == '0 && widx_ff == '0, "counters not cleared in idle")
   `SHA1BSH_ASSERT_NEXT(a_block_folds, state_ff == sha1bsh_pkg::ST_BLOCK && rnd_last, state_ff == sha1bsh_pkg::ST_FOLD, "block rounds did not end in fold")

endmodule

`default_nettype wire

/* sv/sha1bsh_dp.sv */
`default_nettype none

module sha1bsh_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           data_byte,
   input  wire sha1bsh_pkg::cmd_type cmd,
   output sha1bsh_pkg::sts_type      sts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sha1bsh_pkg::rsp_type      rsp_payload
);

   localparam int unsigned W0  = sha1bsh_pkg::BLOCK_W - 1;
   localparam int unsigned W2  = sha1bsh_pkg::BLOCK_W - 1 - 2 * sha1bsh_pkg::WORD_W;
   localparam int unsigned W8  = sha1bsh_pkg::BLOCK_W - 1 - 8 * sha1bsh_pkg::WORD_W;
   localparam int unsigned W13 = sha1bsh_pkg::BLOCK_W - 1 - 13 * sha1bsh_pkg::WORD_W;

   sha1bsh_pkg::word_type chain_ff [sha1bsh_pkg::NUM_WORDS];
   sha1bsh_pkg::word_type chain_in [sha1bsh_pkg::NUM_WORDS];
   sha1bsh_pkg::word_type work_ff  [sha1bsh_pkg::NUM_WORDS];
   sha1bsh_pkg::word_type work_in  [sha1bsh_pkg::NUM_WORDS];

   logic [sha1bsh_pkg::BLOCK_W-1:0] blk_ff, blk_in;
   logic [sha1bsh_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [sha1bsh_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   sha1bsh_pkg::rsp_type            rsp_ff, rsp_in;

   sha1bsh_pkg::word_type sched_mix, wt, temp;

   assign sched_mix = blk_ff[W13 -: sha1bsh_pkg::WORD_W] ^ blk_ff[W8 -: sha1bsh_pkg::WORD_W]
                    ^ blk_ff[W2 -: sha1bsh_pkg::WORD_W] ^ blk_ff[W0 -: sha1bsh_pkg::WORD_W];
   assign wt = (cmd.rnd < sha1bsh_pkg::SCHED_LOAD) ? blk_ff[W0 -: sha1bsh_pkg::WORD_W]
                                                   : {sched_mix[30:0], sched_mix[31]};
   assign temp = {work_ff[0][26:0], work_ff[0][31:27]}
               + sha1bsh_pkg::round_f(cmd.rnd, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + sha1bsh_pkg::round_const(cmd.rnd) + wt;

   always_comb begin
      blk_in   = blk_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      unique case (cmd.shift_sel)
         sha1bsh_pkg::SHIFT_DATA: begin
            blk_in   = {blk_ff[sha1bsh_pkg::BLOCK_W-9:0], data_byte};
            pos_in   = pos_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
         sha1bsh_pkg::SHIFT_MARK: begin
            blk_in = {blk_ff[sha1bsh_pkg::BLOCK_W-9:0], sha1bsh_pkg::PAD_MARK};
            pos_in = pos_ff + 1'b1;
         end
         sha1bsh_pkg::SHIFT_ZERO: begin
            blk_in = {blk_ff[sha1bsh_pkg::BLOCK_W-9:0], 8'h00};
            pos_in = pos_ff + 1'b1;
         end
         sha1bsh_pkg::SHIFT_LEN: begin
            blk_in = {blk_ff[sha1bsh_pkg::BLOCK_W-65:0], count_ff, 3'b000};
            pos_in = pos_ff + sha1bsh_pkg::LEN_BYTES;
         end
         sha1bsh_pkg::SHIFT_NONE: ;
         default: ;
      endcase
      if (cmd.round_en) begin
         blk_in = {blk_ff[sha1bsh_pkg::BLOCK_W-sha1bsh_pkg::WORD_W-1:0], wt};
      end
      if (cmd.init) begin
         count_in = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < sha1bsh_pkg::NUM_WORDS; i++) begin
         chain_in[i] = chain_ff[i];
         work_in[i]  = work_ff[i];
      end
      if (cmd.round_en) begin
         work_in[0] = temp;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
      // working set follows the chain so the next block starts from it
      if (cmd.fold) begin
         for (int i = 0; i < sha1bsh_pkg::NUM_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
            work_in[i]  = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.init) begin
         for (int i = 0; i < sha1bsh_pkg::NUM_WORDS; i++) begin
            chain_in[i] = sha1bsh_pkg::init_word(i[sha1bsh_pkg::WIDX_W-1:0]);
            work_in[i]  = sha1bsh_pkg::init_word(i[sha1bsh_pkg::WIDX_W-1:0]);
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.digest_word    = chain_ff[cmd.word_idx];
         rsp_in.word_last      = (cmd.word_idx == sha1bsh_pkg::LAST_WORD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < sha1bsh_pkg::NUM_WORDS; i++) begin
            chain_ff[i] <= sha1bsh_pkg::init_word(i[sha1bsh_pkg::WIDX_W-1:0]);
            work_ff[i]  <= sha1bsh_pkg::init_word(i[sha1bsh_pkg::WIDX_W-1:0]);
         end
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < sha1bsh_pkg::NUM_WORDS; i++) begin
            chain_ff[i] <= chain_in[i];
            work_ff[i]  <= work_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rsp_ff <= rsp_in;
   end

   assign sts.pos      = pos_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PCT     = 25;
   localparam int DRAIN_CYCLES = 200;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   sha1bsh_pkg::req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   sha1bsh_pkg::rsp_type rsp_payload;

   sha1_byte_stream_hasher u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // running hash state, mirrors the block
   logic [31:0]          chain_h [5];
   logic [7:0]           block_buf [64];
   logic [60:0]          byte_count;
   sha1bsh_pkg::rsp_type expected_words [$];

   int  error_count    = 0;
   int  words_checked  = 0;
   int  messages_sent  = 0;
   int  bytes_sent     = 0;
   int  cycle_count    = 0;
   bit  no_idle        = 1'b0;
   bit  rsp_hold_req   = 1'b0;
   int  hold_count     = 0;

   function automatic void load_initial_chain();
      chain_h[0] = H0;
      chain_h[1] = H1;
      chain_h[2] = H2;
      chain_h[3] = H3;
      chain_h[4] = H4;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) begin
         w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
      end
      for (int r = 16; r < 80; r++) begin
         w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
      end
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + k + w[r];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   // advance the hash for one accepted request, queue digest words on finish
   function automatic void hash_item(input sha1bsh_pkg::req_type item);
      int                   fill;
      logic [63:0]          bit_len;
      sha1bsh_pkg::rsp_type word;
      fill = int'(byte_count[5:0]);
      if (item.op == sha1bsh_pkg::OP_ABSORB) begin
         block_buf[fill] = item.data_byte;
         byte_count = byte_count + 61'd1;
         if (fill == 63) compress_block();
      end else begin
         bit_len = {byte_count, 3'b000};
         block_buf[fill] = PAD_BYTE;
         fill++;
         if (fill > 56) begin
            for (int i = fill; i < 64; i++) block_buf[i] = 8'h00;
            compress_block();
            fill = 0;
         end
         for (int i = fill; i < 56; i++) block_buf[i] = 8'h00;
         for (int i = 0; i < 8; i++) block_buf[63-i] = bit_len[8*i +: 8];
         compress_block();
         for (int i = 0; i < 5; i++) begin
            word.digest_word = chain_h[i];
            word.word_last   = (i == 4);
            expected_words.push_back(word);
         end
         load_initial_chain();
         byte_count = '0;
      end
   endfunction

   initial begin
      load_initial_chain();
      byte_count = '0;
      for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
   end

   // request monitor and digest checker
   always @(posedge clock) begin
      sha1bsh_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) hash_item(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected digest transfer, actual word %h last %b",
                        $time, rsp_payload.digest_word, rsp_payload.word_last);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_payload.digest_word !== want.digest_word ||
                   rsp_payload.word_last !== want.word_last) begin
                  $display("%0t: digest mismatch, expected word %h last %b, actual word %h last %b",
                           $time, want.digest_word, want.word_last,
                           rsp_payload.digest_word, rsp_payload.word_last);
                  error_count++;
               end
               words_checked++;
            end
         end
      end
   end

   // receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_count = 0;
      end else if (rsp_hold_req) begin
         rsp_ready <= 1'b0;
         hold_count++;
         if (hold_count >= HOLD_CYCLES) begin
            hold_count = 0;
            rsp_hold_req = 1'b0;
         end
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d digest words still outstanding",
                  $time, expected_words.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic op, input logic [7:0] data);
      sha1bsh_pkg::req_type item;
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         req_payload <= sha1bsh_pkg::req_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      item.op = op;
      item.data_byte = data;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (op == sha1bsh_pkg::OP_ABSORB) bytes_sent++;
      else messages_sent++;
   endtask

   task automatic send_random_message(input int len);
      for (int i = 0; i < len; i++) send_item(sha1bsh_pkg::OP_ABSORB, 8'($urandom));
      send_item(sha1bsh_pkg::OP_FINISH, 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_message();
      send_item(sha1bsh_pkg::OP_FINISH, 8'h00);
      send_item(sha1bsh_pkg::OP_FINISH, 8'hFF);
   endtask

   task automatic test_short_messages();
      send_item(sha1bsh_pkg::OP_ABSORB, 8'h61);
      send_item(sha1bsh_pkg::OP_ABSORB, 8'h62);
      send_item(sha1bsh_pkg::OP_ABSORB, 8'h63);
      send_item(sha1bsh_pkg::OP_FINISH, 8'h00);
      send_item(sha1bsh_pkg::OP_ABSORB, 8'h00);
      send_item(sha1bsh_pkg::OP_FINISH, 8'hFF);
      send_item(sha1bsh_pkg::OP_ABSORB, 8'hFF);
      send_item(sha1bsh_pkg::OP_FINISH, 8'h00);
      send_item(sha1bsh_pkg::OP_ABSORB, 8'hFF);
      send_item(sha1bsh_pkg::OP_ABSORB, 8'h00);
      send_item(sha1bsh_pkg::OP_ABSORB, 8'hA5);
      send_item(sha1bsh_pkg::OP_ABSORB, 8'h5A);
      send_item(sha1bsh_pkg::OP_FINISH, 8'h80);
   endtask

   // receiver holds off while requests keep coming, then a full drain
   task automatic test_backpressure();
      rsp_hold_req = 1'b1;
      send_random_message(3);
      send_random_message(0);
      send_random_message(70);
      send_random_message(5);
      wait_drained();
   endtask

   task automatic test_random_messages();
      int items;
      int len;
      int pick;
      items = 0;
      while (items < 400) begin
         no_idle = (items >= 100 && items < 220);
         pick = $urandom_range(99);
         if (pick < 50) begin
            case ($urandom_range(11))
               0:       len = 0;
               1:       len = 1;
               2:       len = 55;
               3:       len = 56;
               4:       len = 57;
               5:       len = 63;
               6:       len = 64;
               7:       len = 65;
               8:       len = 119;
               9:       len = 120;
               10:      len = 127;
               default: len = 128;
            endcase
         end else if (pick < 80) begin
            len = $urandom_range(0, 12);
         end else begin
            len = $urandom_range(0, 140);
         end
         send_random_message(len);
         items += len + 1;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_message();
      test_short_messages();
      test_backpressure();
      test_random_messages();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d messages, %0d message bytes, %0d digest words checked",
               messages_sent, bytes_sent, words_checked);
      $display("including empty messages, padding boundaries and a long receiver stall");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
